// ===== rtl/core/admittance_acceleration_2d_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the planar admittance acceleration block
// Shared helpers so that every check is clocked and reset the same way.
// ----------------------------------------------------------------------------
`ifndef ADMITTANCE_ACCELERATION_2D_TOP_MACROS_SVH
`define ADMITTANCE_ACCELERATION_2D_TOP_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define AACC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define AACC_NEVER(lbl, clk, rst, cond, msg) \
  `AACC_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ===== rtl/core/aacc2d_pkg.sv =====
// ----------------------------------------------------------------------------
// aacc2d_pkg
// Types, register codes and the shared divider step of the admittance block.
// ----------------------------------------------------------------------------
package aacc2d_pkg;

  // Register codes, taken from the 8-byte aligned address.
  localparam logic [2:0] REG_LEFT_INERTIA   = 3'd0;
  localparam logic [2:0] REG_LEFT_DAMPING   = 3'd1;
  localparam logic [2:0] REG_LEFT_STIFFNESS = 3'd2;
  localparam logic [2:0] REG_RIGHT_INERTIA  = 3'd3;
  localparam logic [2:0] REG_RIGHT_DAMPING  = 3'd4;
  localparam logic [2:0] REG_RIGHT_STIFFNESS = 3'd5;

  localparam logic [63:0] INERTIA_RESET = 64'h0100_0000_0000_0100;

  // Divider layout: two quotient bits per stage over a 32-bit quotient.
  localparam int unsigned QUO_W          = 32;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  // Six front stages, the divider stages and the output register.
  localparam int unsigned LATENCY        = 6 + DIV_STAGES + 1;

  // One quotient lane moving through the divider.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } lane_t;

  // Control that travels beside the two lanes.
  typedef struct packed {
    logic        arm;
    logic        singular;
    logic [31:0] dmag;
  } div_ctrl_t;

  // Two restoring division steps on one lane.
  function automatic lane_t lane_step(input lane_t a, input logic [31:0] d);
    lane_t       r;
    logic [32:0] t;
    r = a;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t     = {r.rem, r.low[31]};
      r.low = {r.low[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = 32'(t - {1'b0, d});
        r.quo = {r.quo[30:0], 1'b1};
      end else begin
        r.rem = t[31:0];
        r.quo = {r.quo[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/admittance_acceleration_2d_top.sv =====
// ----------------------------------------------------------------------------
// admittance_acceleration_2d_top
// Planar admittance law a = M^-1 (df - D v - K (x - x_eq)) for two arms.
// ----------------------------------------------------------------------------
// The block accepts one request in every clock cycle (busy stays low) and
// returns each result marked by a one-cycle done strobe. The request passes
// through six front stages of multiply, add and sign logic, then a
// sixteen-stage divider that resolves two quotient bits per stage, then the
// output register. Results cannot be held off by the receiver. Matrices are
// written through the APB port at byte address 8*i and must only change while
// no request is in flight.
module admittance_acceleration_2d_top
  import aacc2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // Request
  input  logic               start,
  output logic               busy,
  input  logic               arm,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] rest_x,
  input  logic signed [31:0] rest_y,
  // Result
  output logic               done,
  output logic               arm_out,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic               singular,
  output logic               saturated
);

  // Configuration registers.
  logic [63:0] inertia_lt, damping_lt, stiffness_lt;
  logic [63:0] inertia_rt, damping_rt, stiffness_rt;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_lt   <= INERTIA_RESET;
      damping_lt   <= '0;
      stiffness_lt <= '0;
      inertia_rt   <= INERTIA_RESET;
      damping_rt   <= '0;
      stiffness_rt <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[5:3])
        REG_LEFT_INERTIA:    inertia_lt   <= pwdata;
        REG_LEFT_DAMPING:    damping_lt   <= pwdata;
        REG_LEFT_STIFFNESS:  stiffness_lt <= pwdata;
        REG_RIGHT_INERTIA:   inertia_rt   <= pwdata;
        REG_RIGHT_DAMPING:   damping_rt   <= pwdata;
        REG_RIGHT_STIFFNESS: stiffness_rt <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[5:3])
      REG_LEFT_INERTIA:    prdata = inertia_lt;
      REG_LEFT_DAMPING:    prdata = damping_lt;
      REG_LEFT_STIFFNESS:  prdata = stiffness_lt;
      REG_RIGHT_INERTIA:   prdata = inertia_rt;
      REG_RIGHT_DAMPING:   prdata = damping_rt;
      REG_RIGHT_STIFFNESS: prdata = stiffness_rt;
      default:             prdata = '0;
    endcase
  end

  // Matrix selection for the incoming request.
  logic [63:0] sel_m, sel_d, sel_k;
  assign sel_m = arm ? inertia_rt   : inertia_lt;
  assign sel_d = arm ? damping_rt   : damping_lt;
  assign sel_k = arm ? stiffness_rt : stiffness_lt;

  // Stage 1: unpack entries, position error and determinant products.
  logic               s1_valid, s1_arm;
  logic signed [15:0] s1_m0, s1_m1, s1_m2, s1_m3;
  logic signed [15:0] s1_d0, s1_d1, s1_d2, s1_d3;
  logic signed [15:0] s1_k0, s1_k1, s1_k2, s1_k3;
  logic signed [31:0] s1_vx, s1_vy, s1_fx, s1_fy;
  logic signed [32:0] s1_ex, s1_ey;
  logic signed [31:0] s1_p03, s1_p12;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_arm <= arm;
    s1_m0  <= sel_m[15:0];
    s1_m1  <= sel_m[31:16];
    s1_m2  <= sel_m[47:32];
    s1_m3  <= sel_m[63:48];
    s1_d0  <= sel_d[15:0];
    s1_d1  <= sel_d[31:16];
    s1_d2  <= sel_d[47:32];
    s1_d3  <= sel_d[63:48];
    s1_k0  <= sel_k[15:0];
    s1_k1  <= sel_k[31:16];
    s1_k2  <= sel_k[47:32];
    s1_k3  <= sel_k[63:48];
    s1_vx  <= vel_x;
    s1_vy  <= vel_y;
    s1_fx  <= force_x;
    s1_fy  <= force_y;
    s1_ex  <= 33'(pos_x) - 33'(rest_x);
    s1_ey  <= 33'(pos_y) - 33'(rest_y);
    s1_p03 <= $signed(sel_m[15:0]) * $signed(sel_m[63:48]);
    s1_p12 <= $signed(sel_m[31:16]) * $signed(sel_m[47:32]);
  end

  // Stage 2: damping and stiffness products, determinant.
  logic               s2_valid, s2_arm;
  logic signed [15:0] s2_m0, s2_m1, s2_m2, s2_m3;
  logic signed [31:0] s2_fx, s2_fy;
  logic signed [47:0] s2_dv0, s2_dv1, s2_dv2, s2_dv3;
  logic signed [48:0] s2_ke0, s2_ke1, s2_ke2, s2_ke3;
  logic signed [32:0] s2_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_arm <= s1_arm;
    s2_m0  <= s1_m0;
    s2_m1  <= s1_m1;
    s2_m2  <= s1_m2;
    s2_m3  <= s1_m3;
    s2_fx  <= s1_fx;
    s2_fy  <= s1_fy;
    s2_dv0 <= s1_d0 * s1_vx;
    s2_dv1 <= s1_d1 * s1_vy;
    s2_dv2 <= s1_d2 * s1_vx;
    s2_dv3 <= s1_d3 * s1_vy;
    s2_ke0 <= s1_k0 * s1_ex;
    s2_ke1 <= s1_k1 * s1_ey;
    s2_ke2 <= s1_k2 * s1_ex;
    s2_ke3 <= s1_k3 * s1_ey;
    s2_det <= 33'(s1_p03) - 33'(s1_p12);
  end

  // Stage 3: right-hand side w and adjugate coefficients.
  logic               s3_valid, s3_arm;
  logic signed [51:0] s3_wx, s3_wy;
  logic signed [16:0] s3_ax1, s3_ax2, s3_ay1, s3_ay2;
  logic signed [32:0] s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_arm <= s2_arm;
    s3_wx  <= (52'(s2_fx) <<< 8) - 52'(s2_dv0) - 52'(s2_dv1)
              - 52'(s2_ke0) - 52'(s2_ke1);
    s3_wy  <= (52'(s2_fy) <<< 8) - 52'(s2_dv2) - 52'(s2_dv3)
              - 52'(s2_ke2) - 52'(s2_ke3);
    s3_ax1 <= 17'(s2_m3);
    s3_ax2 <= -17'(s2_m1);
    s3_ay1 <= -17'(s2_m2);
    s3_ay2 <= 17'(s2_m0);
    s3_det <= s2_det;
  end

  // Stage 4: adjugate products.
  logic               s4_valid, s4_arm;
  logic signed [68:0] s4_px1, s4_px2, s4_py1, s4_py2;
  logic signed [32:0] s4_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_arm <= s3_arm;
    s4_px1 <= s3_ax1 * s3_wx;
    s4_px2 <= s3_ax2 * s3_wy;
    s4_py1 <= s3_ay1 * s3_wx;
    s4_py2 <= s3_ay2 * s3_wy;
    s4_det <= s3_det;
  end

  // Stage 5: numerators.
  logic               s5_valid, s5_arm;
  logic signed [69:0] s5_nx, s5_ny;
  logic signed [32:0] s5_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_arm <= s4_arm;
    s5_nx  <= 70'(s4_px1) + 70'(s4_px2);
    s5_ny  <= 70'(s4_py1) + 70'(s4_py2);
    s5_det <= s4_det;
  end

  // Stage 6: magnitudes, signs and overflow checks feed the divider.
  logic [69:0] nx_mag, ny_mag;
  logic [31:0] det_mag;
  logic        det_neg;

  assign nx_mag  = s5_nx[69] ? 70'(-s5_nx) : 70'(s5_nx);
  assign ny_mag  = s5_ny[69] ? 70'(-s5_ny) : 70'(s5_ny);
  assign det_neg = s5_det[32];
  assign det_mag = det_neg ? 32'(-s5_det) : s5_det[31:0];

  logic      dv_valid [0:DIV_STAGES];
  lane_t     lx [0:DIV_STAGES];
  lane_t     ly [0:DIV_STAGES];
  div_ctrl_t dc [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    lx[0].rem <= nx_mag[63:32];
    lx[0].low <= nx_mag[31:0];
    lx[0].quo <= '0;
    lx[0].neg <= s5_nx[69] ^ det_neg;
    lx[0].ovf <= nx_mag[69:32] >= {6'b0, det_mag};
    ly[0].rem <= ny_mag[63:32];
    ly[0].low <= ny_mag[31:0];
    ly[0].quo <= '0;
    ly[0].neg <= s5_ny[69] ^ det_neg;
    ly[0].ovf <= ny_mag[69:32] >= {6'b0, det_mag};
    dc[0].arm      <= s5_arm;
    dc[0].singular <= (s5_det == '0);
    dc[0].dmag     <= det_mag;
  end

  // Divider stages, two quotient bits each.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      lx[g+1] <= lane_step(lx[g], dc[g].dmag);
      ly[g+1] <= lane_step(ly[g], dc[g].dmag);
      dc[g+1] <= dc[g];
    end
  end

  // Saturation and sign of the final quotients.
  lane_t       fx_lane, fy_lane;
  logic        sat_x, sat_y;
  logic [31:0] res_x, res_y;

  assign fx_lane = lx[DIV_STAGES];
  assign fy_lane = ly[DIV_STAGES];
  assign sat_x = fx_lane.ovf ||
                 (fx_lane.neg ? (fx_lane.quo > 32'h8000_0000) : fx_lane.quo[31]);
  assign sat_y = fy_lane.ovf ||
                 (fy_lane.neg ? (fy_lane.quo > 32'h8000_0000) : fy_lane.quo[31]);

  always_comb begin
    if (sat_x) begin
      res_x = fx_lane.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_x = fx_lane.neg ? 32'(-fx_lane.quo) : fx_lane.quo;
    end
    if (sat_y) begin
      res_y = fy_lane.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_y = fy_lane.neg ? 32'(-fy_lane.quo) : fy_lane.quo;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    arm_out <= dc[DIV_STAGES].arm;
    if (dc[DIV_STAGES].singular) begin
      accel_x   <= '0;
      accel_y   <= '0;
      singular  <= 1'b1;
      saturated <= 1'b0;
    end else begin
      accel_x   <= res_x;
      accel_y   <= res_y;
      singular  <= 1'b0;
      saturated <= sat_x || sat_y;
    end
  end

endmodule

// ===== rtl/core/aacc2d_checker.sv =====
// ----------------------------------------------------------------------------
// aacc2d_checker
// Port-level checks on request and result timing of the admittance block.
// ----------------------------------------------------------------------------
`include "admittance_acceleration_2d_top_macros.svh"

module aacc2d_checker
  import aacc2d_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               arm,
  input logic               done,
  input logic               arm_out,
  input logic signed [31:0] accel_x,
  input logic signed [31:0] accel_y,
  input logic               singular,
  input logic               saturated
);

  // A singular result that carries a nonzero value or a saturation flag.
  logic sing_nonzero;
  assign sing_nonzero = done && singular && (accel_x != '0 || accel_y != '0 || saturated);

  // Every accepted request is answered by a done result.
  `AACC_ASSERT(a_req_returns, clk, rst, (start && !busy) |-> ##LATENCY done, "lost request")

  // A result is only shown for a request that was accepted.
  `AACC_ASSERT(a_no_phantom, clk, rst, done |-> $past(start && !busy, LATENCY), "extra result")

  // The result belongs to the arm that was requested.
  `AACC_ASSERT(a_arm_match, clk, rst, done |-> (arm_out == $past(arm, LATENCY)), "wrong arm")

  // A singular inertia gives zero acceleration and no saturation.
  `AACC_NEVER(a_singular_zero, clk, rst, sing_nonzero, "singular result not zero")

endmodule

bind admittance_acceleration_2d_top aacc2d_checker u_aacc2d_checker (.*);
